FILE: design/u16u8_pkg.sv
// package with shared types and constants for the utf-16 to utf-8 encoder
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

  localparam int unsigned UnitW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned MaxBytes  = 4;
  localparam int unsigned IdxW      = $clog2(MaxBytes);
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  // classification of one incoming code unit
  typedef enum logic [2:0] {
    CLS_ONE,
    CLS_TWO,
    CLS_THREE,
    CLS_LEAD,
    CLS_PAIR
  } cls_e;

  // one queue entry: up to four bytes and the index of the final byte
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [IdxW-1:0]                last_idx;
  } entry_t;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

FILE: design/u16u8_front.sv
// front part: accepts code units, tracks surrogate pairs, builds byte groups
`timescale 1ns / 1ps
`default_nettype none

module u16u8_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [u16u8_pkg::UnitW-1:0]   code_unit_i,
  input  wire u16u8_pkg::q_status_t          q_status_i,
  output logic                               push_o,
  output u16u8_pkg::entry_t                  entry_o
);
  import u16u8_pkg::*;

  logic        pending_q, pending_d;
  logic [9:0]  high_q, high_d;
  logic [20:0] cp;
  cls_e        cls;
  logic        accept;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;

  always_comb begin
    cp = 21'h10000 + {1'b0, high_q, code_unit_i[9:0]};
    if (pending_q) begin
      cls = CLS_PAIR;
    end else if (code_unit_i[15:7] == '0) begin
      cls = CLS_ONE;
    end else if (code_unit_i[15:11] == 5'b11011) begin
      cls = CLS_LEAD;
    end else if (code_unit_i[15:11] == '0) begin
      cls = CLS_TWO;
    end else begin
      cls = CLS_THREE;
    end
  end

  always_comb begin
    entry_o   = '0;
    push_o    = 1'b0;
    pending_d = pending_q;
    high_d    = high_q;
    unique case (cls)
      CLS_ONE: begin
        entry_o.bytes[0] = {1'b0, code_unit_i[6:0]};
        entry_o.last_idx = IdxW'(0);
      end
      CLS_TWO: begin
        entry_o.bytes[0] = {3'b110, code_unit_i[10:6]};
        entry_o.bytes[1] = {2'b10, code_unit_i[5:0]};
        entry_o.last_idx = IdxW'(1);
      end
      CLS_THREE: begin
        entry_o.bytes[0] = {4'b1110, code_unit_i[15:12]};
        entry_o.bytes[1] = {2'b10, code_unit_i[11:6]};
        entry_o.bytes[2] = {2'b10, code_unit_i[5:0]};
        entry_o.last_idx = IdxW'(2);
      end
      CLS_PAIR: begin
        entry_o.bytes[0] = {5'b11110, cp[20:18]};
        entry_o.bytes[1] = {2'b10, cp[17:12]};
        entry_o.bytes[2] = {2'b10, cp[11:6]};
        entry_o.bytes[3] = {2'b10, cp[5:0]};
        entry_o.last_idx = IdxW'(3);
      end
      CLS_LEAD: begin
        entry_o.last_idx = IdxW'(0);
      end
      default: begin
        entry_o.last_idx = IdxW'(0);
      end
    endcase
    if (accept) begin
      push_o = (cls != CLS_LEAD);
      if (cls == CLS_LEAD) begin
        pending_d = 1'b1;
        high_d    = code_unit_i[9:0];
      end else if (cls == CLS_PAIR) begin
        pending_d = 1'b0;
        high_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      high_q    <= '0;
    end else begin
      pending_q <= pending_d;
      high_q    <= high_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/u16u8_fifo.sv
// short queue of byte groups between the front and back parts
`timescale 1ns / 1ps
`default_nettype none

module u16u8_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire u16u8_pkg::entry_t     wdata_i,
  input  wire logic                  pop_i,
  output u16u8_pkg::entry_t          rdata_o,
  output u16u8_pkg::q_status_t       status_o
);
  import u16u8_pkg::*;

  entry_t            mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/u16u8_back.sv
// back part: sends the bytes of each queued group one per cycle while out_stall_i is low
`timescale 1ns / 1ps
`default_nettype none

module u16u8_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire u16u8_pkg::entry_t             head_i,
  input  wire u16u8_pkg::q_status_t          q_status_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [u16u8_pkg::ByteW-1:0]        out_byte_o,
  output logic                               last_byte_o
);
  import u16u8_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            accept;

  assign out_valid_o = !q_status_i.empty;
  assign out_byte_o  = head_i.bytes[idx_q];
  assign last_byte_o = (idx_q == head_i.last_idx);
  assign accept      = out_valid_o && !out_stall_i;
  assign pop_o       = accept && last_byte_o;

  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      idx_d = last_byte_o ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/utf16_to_utf8_encoder.sv
// top level of the utf-16 to utf-8 encoder
// an accepted item's byte group is registered in the queue; its first byte is valid once earlier groups are sent
// throughput: one byte per cycle from the back serializer while out_stall_i is low, 1 to 4 bytes per item
// a leading surrogate is accepted but gives no byte; the 4-entry queue absorbs bursts
// reset clears the pending surrogate, the queue and the byte index
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_encoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [u16u8_pkg::UnitW-1:0]   code_unit_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [u16u8_pkg::ByteW-1:0]        out_byte_o,
  output logic                               last_byte_o
);
  import u16u8_pkg::*;

  q_status_t q_status;
  entry_t    push_entry;
  entry_t    head_entry;
  logic      push;
  logic      pop;

  u16u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .code_unit_i (code_unit_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  u16u8_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_entry),
    .pop_i    (pop),
    .rdata_o  (head_entry),
    .status_o (q_status)
  );

  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_entry),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

`default_nettype wire

FILE: tb/utf16_to_utf8_encoder_test.sv
// self-checking testbench for the utf-16 to utf-8 encoder with a byte predictor class
`timescale 1ns / 1ps

class Utf8BytePredictor;
  typedef struct packed {
    logic [u16u8_pkg::ByteW-1:0] octet;
    logic                        last;
  } octet_t;

  localparam logic [15:0] OneByteLimit  = 16'h0080;
  localparam logic [15:0] TwoByteMask   = 16'hf800;
  localparam logic [15:0] SurrogateLow  = 16'hd800;
  localparam logic [15:0] SurrogateHigh = 16'he000;
  localparam logic [20:0] PlaneOneBase  = 21'h10000;

  bit          surrogate_held;
  logic [9:0]  lead_bits;
  octet_t      expected_octets[$];
  int unsigned mismatches;

  function new();
    surrogate_held = 1'b0;
    lead_bits      = '0;
    mismatches     = 0;
  endfunction

  function void push_octet(logic [7:0] value, logic last);
    octet_t entry;
    entry.octet = value;
    entry.last  = last;
    expected_octets.push_back(entry);
  endfunction

  function void note_unit(logic [u16u8_pkg::UnitW-1:0] cu);
    logic [20:0] cp;
    if (surrogate_held) begin
      cp = PlaneOneBase + {lead_bits, 10'b0} + cu[9:0];
      surrogate_held = 1'b0;
      lead_bits      = '0;
      push_octet({5'b11110, cp[20:18]}, 1'b0);
      push_octet({2'b10, cp[17:12]}, 1'b0);
      push_octet({2'b10, cp[11:6]}, 1'b0);
      push_octet({2'b10, cp[5:0]}, 1'b1);
    end else if (cu < OneByteLimit) begin
      push_octet(cu[7:0], 1'b1);
    end else if (cu >= SurrogateLow && cu < SurrogateHigh) begin
      lead_bits      = cu[9:0];
      surrogate_held = 1'b1;
    end else if ((cu & TwoByteMask) == 16'h0000) begin
      push_octet({3'b110, cu[10:6]}, 1'b0);
      push_octet({2'b10, cu[5:0]}, 1'b1);
    end else begin
      push_octet({4'b1110, cu[15:12]}, 1'b0);
      push_octet({2'b10, cu[11:6]}, 1'b0);
      push_octet({2'b10, cu[5:0]}, 1'b1);
    end
  endfunction

  function void check_byte(logic [u16u8_pkg::ByteW-1:0] value, logic last);
    octet_t want;
    if (expected_octets.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected byte %02h last %0b with nothing pending", value, last);
      return;
    end
    want = expected_octets.pop_front();
    if (want.octet !== value || want.last !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                 want.octet, want.last, value, last);
    end
  endfunction
endclass

module utf16_to_utf8_encoder_test;
  import u16u8_pkg::*;

  typedef enum int {
    KIND_ASCII,
    KIND_TWO,
    KIND_THREE,
    KIND_PAIR,
    KIND_NOISE
  } unit_kind_e;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  logic [UnitW-1:0] code_unit_i  = '0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  logic [ByteW-1:0] out_byte_o;
  logic             last_byte_o;

  Utf8BytePredictor predictor = new();
  int unsigned      units_sent  = 0;
  int unsigned      tx_idle_pct = 7;
  int unsigned      rx_idle_pct = 63;
  bit               hold_off    = 1'b0;

  utf16_to_utf8_encoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .code_unit_i (code_unit_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("utf16_to_utf8_encoder_test: FAIL");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      predictor.check_byte(out_byte_o, last_byte_o);
  end

  // long receiver hold-off so the internal queue fills and the input stalls
  initial begin
    wait (units_sent >= 30);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (160) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic send_unit(input logic [UnitW-1:0] cu);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    code_unit_i <= cu;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predictor.note_unit(cu);
    units_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random_group();
    unit_kind_e kind;
    kind = unit_kind_e'($urandom_range(4));
    case (kind)
      KIND_ASCII: begin
        send_unit(16'($urandom_range(16'h007f)));
      end
      KIND_TWO: begin
        send_unit(16'($urandom_range(16'h07ff, 16'h0080)));
      end
      KIND_THREE: begin
        if ($urandom_range(1))
          send_unit(16'($urandom_range(16'hd7ff, 16'h0800)));
        else
          send_unit(16'($urandom_range(16'hffff, 16'he000)));
      end
      KIND_PAIR: begin
        send_unit(16'($urandom_range(16'hdbff, 16'hd800)));
        send_unit(16'($urandom_range(16'hdfff, 16'hdc00)));
      end
      default: begin
        send_unit(16'($urandom()));
      end
    endcase
  endtask

  initial begin
    static logic [UnitW-1:0] directed_units[] = '{
      16'h0000, 16'h007f, 16'h0080, 16'h07ff, 16'h0800, 16'hffff,
      16'hd7ff, 16'he000, 16'h1234, 16'habcd,
      16'hd800, 16'hdc00,
      16'hdbff, 16'hdfff,
      16'hdc00, 16'h0041,
      16'hd800, 16'hd800,
      16'hd812, 16'h0000,
      16'hdabc, 16'hffff
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_units[i]) send_unit(directed_units[i]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct <= 7;
          rx_idle_pct <= 63;
        end
        1: begin
          tx_idle_pct <= 63;
          rx_idle_pct <= 7;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      repeat (40) send_random_group();
    end
    in_valid_i <= 1'b0;

    while (predictor.expected_octets.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    if (predictor.mismatches == 0 && predictor.expected_octets.size() == 0) begin
      $display("utf16_to_utf8_encoder_test: PASS");
    end else begin
      $display("utf16_to_utf8_encoder_test: FAIL");
    end
    $finish;
  end
endmodule

FILE: files.f
design/u16u8_pkg.sv
design/u16u8_front.sv
design/u16u8_fifo.sv
design/u16u8_back.sv
design/utf16_to_utf8_encoder.sv
tb/utf16_to_utf8_encoder_test.sv
